FILE: sv/ipru_pkg.sv
// Shared types and constants for the pixel replication upscaler.
`timescale 1ns / 1ps
package ipru_pkg;

	localparam int PIX_W  = 24;
	localparam int PAD_W  = 2;
	// copy count field, wide enough for the largest scale the 5-bit scale field can set (31)
	localparam int CNT_W  = 7;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// configuration register indexes
	localparam logic REG_SCALE     = 1'b0;
	localparam logic REG_ROW_WIDTH = 1'b1;

	// one classified item waiting for the emitter
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic [CNT_W-1:0] copies;
		logic             row_end;
		logic [PAD_W-1:0] pad;
		logic             replay;
		logic             err;
	} job_t;

endpackage

FILE: sv/integer_pixel_replication_upscaler.sv
// Top level of the integer pixel replication upscaler.
`timescale 1ns / 1ps
// Nearest-neighbor upscaler for 24-bit pixels. Send a row of pixels (tuser = 0), then
// scale-1 rows of drain ticks (tuser = 1, one per column); each accepted request yields
// scale output beats, or one beat with tuser set if its kind does not fit the current mode.
// The emitter puts out one beat per cycle while the output is ready, so the scale beats
// (1 to MAX_SCALE) of successive requests stream out back to back, and requests are taken
// back to back while the four-entry job queue has room. The line store needs no
// initialization pass. Configuration writes are always ready and abort the current row.
module integer_pixel_replication_upscaler #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_SCALE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_addr,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // pixel[23:0]
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // pixel_out[23:0], row_end, pad_bytes[1:0], replay_active
	output logic        m_axis_tlast,
	output logic        m_axis_tuser    // error
);
	import ipru_pkg::*;

	logic              push;
	job_t              push_job;
	logic              pop;
	logic              q_valid;
	job_t              q_job;
	logic [QCNT_W-1:0] q_count;

	assign cfg_ready = 1'b1;

	ipru_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_SCALE(MAX_SCALE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.in_pixel (s_axis_tdata),
		.q_count  (q_count),
		.push     (push),
		.push_job (push_job)
	);

	ipru_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.q_valid (q_valid),
		.q_job   (q_job),
		.q_count (q_count)
	);

	ipru_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_job        (q_job),
		.pop          (pop),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.m_axis_tuser (m_axis_tuser)
	);

endmodule

FILE: sv/ipru_front.sv
// Front end: accepts requests, keeps the row state and line store, builds jobs.
`timescale 1ns / 1ps
module ipru_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAX_SCALE = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_addr,
	input  logic [11:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_kind,
	input  logic [23:0]          in_pixel,
	input  logic [ipru_pkg::QCNT_W-1:0] q_count,
	output logic                 push,
	output ipru_pkg::job_t       push_job
);
	import ipru_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = CW + 1;
	localparam int SW = $clog2(MAX_SCALE + 1);

	logic [SW-1:0]    eff_s_q;
	logic [WW-1:0]    eff_w_q;
	logic [CW-1:0]    column_q;
	logic [SW-1:0]    replays_left_q;
	logic             in_replay_q;

	logic [PIX_W-1:0] line_mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_q;

	logic             valid_s1;
	logic             from_mem_s1;
	job_t             job_s1;

	logic             accept;
	logic             mismatch;
	logic [CW-1:0]    col;
	logic             rend;
	logic             rep_next;
	logic [SW-1:0]    left_dec;
	logic [1:0]       wl, sl, prod, pad;

	assign in_ready = (QCNT_W'(q_count) + QCNT_W'(valid_s1)) < QCNT_W'(QDEPTH);
	assign accept   = in_valid && in_ready;
	assign mismatch = in_kind != in_replay_q;
	assign col      = ({1'b0, column_q} >= eff_w_q) ? '0 : column_q;
	assign rend     = (WW'(col) + WW'(1)) == eff_w_q;

	// pad = (4 - w*s*3 mod 4) mod 4, only the low two bits matter
	assign wl   = eff_w_q[1:0];
	assign sl   = 2'(eff_s_q);
	assign prod = 2'(wl * sl * 2'd3);
	assign pad  = 2'(2'd0 - prod);

	assign left_dec = (replays_left_q != '0) ? replays_left_q - SW'(1) : replays_left_q;

	always_comb begin
		rep_next = in_replay_q;
		if (rend) begin
			if (!in_kind) begin
				if (eff_s_q > SW'(1)) rep_next = 1'b1;
			end else if (left_dec == '0) begin
				rep_next = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_s_q        <= SW'(1);
			eff_w_q        <= WW'(1);
			column_q       <= '0;
			replays_left_q <= '0;
			in_replay_q    <= 1'b0;
		end else if (cfg_valid) begin
			// a write aborts the row in progress
			column_q       <= '0;
			replays_left_q <= '0;
			in_replay_q    <= 1'b0;
			case (cfg_addr)
				REG_SCALE: begin
					if (cfg_data[4:0] == 5'd0)
						eff_s_q <= SW'(1);
					else if (32'(cfg_data[4:0]) > MAX_SCALE)
						eff_s_q <= SW'(MAX_SCALE);
					else
						eff_s_q <= SW'(cfg_data[4:0]);
				end
				REG_ROW_WIDTH: begin
					if (cfg_data == 12'd0)
						eff_w_q <= WW'(1);
					else if (32'(cfg_data) > MAX_WIDTH)
						eff_w_q <= WW'(MAX_WIDTH);
					else
						eff_w_q <= WW'(cfg_data);
				end
				default: begin
					eff_s_q <= eff_s_q;
				end
			endcase
		end else if (accept && !mismatch) begin
			in_replay_q <= rep_next;
			if (rend) begin
				column_q <= '0;
				if (!in_kind) begin
					if (eff_s_q > SW'(1)) replays_left_q <= eff_s_q - SW'(1);
				end else begin
					replays_left_q <= left_dec;
				end
			end else begin
				column_q <= CW'(col + CW'(1));
			end
		end
	end

	// line store: written by pixels, read by drain ticks
	always_ff @(posedge clk) begin
		if (accept && !mismatch && !in_kind)
			line_mem[col] <= in_pixel;
		if (accept && in_kind)
			rd_q <= line_mem[col];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_mem_s1 <= in_kind && !mismatch;
			if (mismatch) begin
				job_s1.pixel   <= '0;
				job_s1.copies  <= CNT_W'(1);
				job_s1.row_end <= 1'b0;
				job_s1.pad     <= '0;
				job_s1.replay  <= in_replay_q;
				job_s1.err     <= 1'b1;
			end else begin
				job_s1.pixel   <= in_pixel;
				job_s1.copies  <= CNT_W'(eff_s_q);
				job_s1.row_end <= rend;
				job_s1.pad     <= rend ? pad : '0;
				job_s1.replay  <= rep_next;
				job_s1.err     <= 1'b0;
			end
		end
	end

	always_comb begin
		push_job = job_s1;
		if (from_mem_s1) push_job.pixel = rd_q;
	end
	assign push = valid_s1;

	a_replay_needs_scale: assert property (@(posedge clk) disable iff (!arst_n)
		in_replay_q |-> (eff_s_q > SW'(1)))
		else $error("replay mode with scale of one");

	a_column_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, column_q} < eff_w_q)
		else $error("column beyond row width");

endmodule

FILE: sv/ipru_queue.sv
// Short job queue between the front end and the emitter.
`timescale 1ns / 1ps
module ipru_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  ipru_pkg::job_t              push_job,
	input  logic                        pop,
	output logic                        q_valid,
	output ipru_pkg::job_t              q_job,
	output logic [ipru_pkg::QCNT_W-1:0] q_count
);
	import ipru_pkg::*;

	job_t              entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign do_pop  = pop && (count_q != '0);
	assign q_valid = count_q != '0;
	assign q_job   = entry_q[rd_ptr_q];
	assign q_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= QPTR_W'(wr_ptr_q + QPTR_W'(1));
			if (do_pop) rd_ptr_q <= QPTR_W'(rd_ptr_q + QPTR_W'(1));
			count_q <= QCNT_W'(count_q + QCNT_W'(push) - QCNT_W'(do_pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_job;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < QCNT_W'(QDEPTH)) || do_pop)
		else $error("job queue overflow");

endmodule

FILE: sv/ipru_back.sv
// Emitter: expands each job into its copies through an output register.
`timescale 1ns / 1ps
module ipru_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  ipru_pkg::job_t q_job,
	output logic           pop,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [31:0]    m_axis_tdata,  // pixel_out[23:0], row_end, pad_bytes[1:0], replay_active
	output logic           m_axis_tlast,
	output logic           m_axis_tuser   // error
);
	import ipru_pkg::*;

	job_t             cur_q;
	logic             cur_valid_q;
	logic [CNT_W-1:0] copy_q;
	logic             advance;
	logic             cur_last;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             out_last_q;
	logic             out_rend_q;
	logic [PAD_W-1:0] out_pad_q;
	logic             out_rep_q;
	logic             out_err_q;

	assign advance  = !out_valid_q || m_axis_tready;
	assign cur_last = CNT_W'(copy_q + CNT_W'(1)) == cur_q.copies;
	assign pop      = q_valid && (!cur_valid_q || (advance && cur_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop)
				cur_valid_q <= 1'b1;
			else if (advance && cur_valid_q && cur_last)
				cur_valid_q <= 1'b0;
			if (advance) out_valid_q <= cur_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= q_job;
			copy_q <= '0;
		end else if (advance && cur_valid_q) begin
			copy_q <= CNT_W'(copy_q + CNT_W'(1));
		end
		if (advance && cur_valid_q) begin
			out_pixel_q <= cur_q.pixel;
			out_last_q  <= cur_last;
			out_rend_q  <= cur_last && cur_q.row_end;
			out_pad_q   <= (cur_last && cur_q.row_end) ? cur_q.pad : '0;
			out_rep_q   <= cur_q.replay;
			out_err_q   <= cur_q.err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_rep_q, out_pad_q, out_rend_q, out_pixel_q};
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_err_q;

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_err_q) |-> (out_last_q && !out_rend_q))
		else $error("error result not a single last copy");

	a_copy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (copy_q < cur_q.copies))
		else $error("copy counter ran past job");

endmodule
